[rtl/core/mhsm_pkg.sv]
// Package with the sizes, types and state encoding of the MinHash signature match block.
`default_nettype none
package mhsm_pkg;
  localparam int MAX_ENTRIES = 1024;
  localparam int MAX_HASHES  = 64;
  localparam int MAX_TOP     = 16;

  localparam int ENT_W  = $clog2(MAX_ENTRIES);
  localparam int TOT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CNT_W  = $clog2(MAX_HASHES + 1);
  localparam int POS_W  = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int SIG_AW = $clog2(MAX_ENTRIES * MAX_HASHES);
  localparam int TOP_W  = $clog2(MAX_TOP + 1);

  localparam int HASH_W = 32;
  localparam int ID_W   = 64;
  localparam int MC_W   = 7;
  localparam int CT_W   = 11;
  localparam int TC_W   = 5;
  localparam int IN_W   = 168;
  localparam int OUT_W  = 160;
  localparam int KEY_W  = CNT_W + 2 * ID_W + ENT_W;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SEL,
    S_EMIT,
    S_CLEAR
  } state_t;
endpackage
`default_nettype wire

[rtl/core/minhash_signature_match_top_n.sv]
// Top level of the MinHash signature store with top-N similarity search.
`default_nettype none
// Add requests write one hash per request into the next free entry; the last add request of a
// signature returns one row, and no request is taken until that row is accepted. Each query
// request walks all stored entries through the signature, length and score memories at one
// entry per cycle. The last query request then spends, for each reported row, a scan over the
// score and id memories plus a step that loads the result register, which waits while the
// previous row is stalled. A final pass clears the scores. With no row to report, a single
// empty row follows the last scan directly. No request is taken until all of this is over and
// the last row has been accepted. Reset needs no clearing pass, since each new entry clears its
// own score.
module minhash_signature_match_top_n (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_tvalid,
  output logic                     in_tready,
  // hash, source_file, source_address, top_count, zero fill
  input  wire [mhsm_pkg::IN_W-1:0] in_tdata,
  // opcode
  input  wire                      in_tuser,
  // end_of_signature
  input  wire                      in_tlast,
  output logic                     out_tvalid,
  input  wire                      out_tready,
  // match_count, hash_count, found_file, found_address, candidate_total, zero fill
  output logic [mhsm_pkg::OUT_W-1:0] out_tdata,
  // entry_valid, status
  output logic [1:0]               out_tuser,
  // last_result
  output logic                     out_tlast
);
  import mhsm_pkg::*;

  logic [HASH_W-1:0] sig_mem [MAX_ENTRIES*MAX_HASHES];
  logic [CNT_W-1:0]  len_mem [MAX_ENTRIES];
  logic [ID_W-1:0]   file_mem [MAX_ENTRIES];
  logic [ID_W-1:0]   addr_mem [MAX_ENTRIES];
  logic [CNT_W-1:0]  score_mem [MAX_ENTRIES];

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  pos_r;
  logic [TOT_W-1:0]  total_r, cnt_r, cand_r;
  logic              rd_vld_r;
  logic [ENT_W-1:0]  rd_idx_r;
  logic [HASH_W-1:0] hash_r;
  logic              last_r;
  logic [TC_W-1:0]   top_r;
  logic [CNT_W-1:0]  hc_r;
  logic [TOP_W-1:0]  want_r, k_r;
  logic              have_r;
  logic [KEY_W-1:0]  best_key_r, prev_key_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;
  logic [1:0]        out_user_r;
  logic              out_last_r;

  logic [HASH_W-1:0] sig_q;
  logic [CNT_W-1:0]  len_q, score_q;
  logic [ID_W-1:0]   file_q, addr_q;

  logic [HASH_W-1:0] in_hash;
  logic [ID_W-1:0]   in_file, in_addr;
  logic [TC_W-1:0]   in_top;
  assign in_hash = in_tdata[HASH_W-1:0];
  assign in_file = in_tdata[HASH_W+ID_W-1:HASH_W];
  assign in_addr = in_tdata[HASH_W+2*ID_W-1:HASH_W+ID_W];
  assign in_top  = in_tdata[HASH_W+2*ID_W+TC_W-1:HASH_W+2*ID_W];

  logic in_acc, full, pos_ok, issue, done;
  logic [CNT_W-1:0] pos_inc;
  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (total_r == TOT_W'(MAX_ENTRIES));
  assign pos_ok    = (pos_r < CNT_W'(MAX_HASHES));
  assign pos_inc   = pos_ok ? pos_r + 1'b1 : pos_r;
  assign issue     = (cnt_r < total_r);
  assign done      = !issue && !rd_vld_r;

  logic              sig_we, meta_we, score_we;
  logic [SIG_AW-1:0] sig_waddr, sig_raddr;
  logic [ENT_W-1:0]  score_waddr, rd_addr;
  logic [CNT_W-1:0]  score_wdata, new_score;
  logic              hit;
  logic [KEY_W-1:0]  key_q;
  logic              take;

  always_comb begin
    sig_we      = 1'b0;
    meta_we     = 1'b0;
    score_we    = 1'b0;
    score_waddr = total_r[ENT_W-1:0];
    score_wdata = '0;
    rd_addr     = cnt_r[ENT_W-1:0];
    sig_waddr   = SIG_AW'(total_r[ENT_W-1:0]) * SIG_AW'(MAX_HASHES) + SIG_AW'(pos_r[POS_W-1:0]);
    sig_raddr   = SIG_AW'(rd_addr) * SIG_AW'(MAX_HASHES) + SIG_AW'(pos_r[POS_W-1:0]);
    hit         = pos_ok && (pos_r < len_q) && (sig_q == hash_r);
    new_score   = score_q + CNT_W'(hit);
    key_q       = {score_q, file_q, addr_q, ~rd_idx_r};
    take        = (score_q != '0) && ((k_r == '0) || (key_q < prev_key_r)) &&
                  (!have_r || (key_q > best_key_r));
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser == OP_ADD && !full) begin
          sig_we   = pos_ok;
          meta_we  = in_tlast;
          score_we = in_tlast;
        end
      end
      S_SCAN: begin
        if (rd_vld_r) begin
          score_we    = 1'b1;
          score_waddr = rd_idx_r;
          score_wdata = new_score;
        end
      end
      S_CLEAR: begin
        score_we    = issue;
        score_waddr = cnt_r[ENT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_tuser == OP_QUERY) state_nxt = S_SCAN;
      S_SCAN: begin
        if (done) begin
          if (!last_r) state_nxt = S_IDLE;
          else if (TOT_W'(MAX_TOP) > cand_r && TOT_W'(top_r) > cand_r && cand_r == '0)
            state_nxt = S_EMIT;
          else if (top_r == '0) state_nxt = S_EMIT;
          else state_nxt = S_SEL;
        end
      end
      S_SEL:   if (done) state_nxt = S_EMIT;
      S_EMIT: begin
        if (!out_valid_r) begin
          if (have_r && (k_r + 1'b1 != want_r)) state_nxt = S_SEL;
          else state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: if (!issue) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sig_we) sig_mem[sig_waddr] <= in_hash;
    if (meta_we) begin
      len_mem[total_r[ENT_W-1:0]]  <= pos_inc;
      file_mem[total_r[ENT_W-1:0]] <= in_file;
      addr_mem[total_r[ENT_W-1:0]] <= in_addr;
    end
    if (score_we) score_mem[score_waddr] <= score_wdata;
    sig_q   <= sig_mem[sig_raddr];
    len_q   <= len_mem[rd_addr];
    file_q  <= file_mem[rd_addr];
    addr_q  <= addr_mem[rd_addr];
    score_q <= score_mem[rd_addr];
  end

  logic [TOT_W-1:0] want_calc;
  always_comb begin
    want_calc = (in_top > TC_W'(MAX_TOP)) ? TOT_W'(MAX_TOP) : TOT_W'(top_r);
    if (TOT_W'(top_r) < TOT_W'(MAX_TOP)) want_calc = TOT_W'(top_r);
    else want_calc = TOT_W'(MAX_TOP);
    if (want_calc > cand_r) want_calc = cand_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      total_r     <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      have_r      <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      rd_vld_r <= ((state_r == S_SCAN) || (state_r == S_SEL)) && issue;
      rd_idx_r <= cnt_r[ENT_W-1:0];
      if (((state_r == S_SCAN) || (state_r == S_SEL) || (state_r == S_CLEAR)) && issue)
        cnt_r <= cnt_r + 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            hash_r <= in_hash;
            last_r <= in_tlast;
            top_r  <= in_top;
            cnt_r  <= '0;
            cand_r <= '0;
            if (in_tuser == OP_ADD) begin
              pos_r <= in_tlast ? '0 : pos_inc;
              if (in_tlast) begin
                if (!full) total_r <= total_r + 1'b1;
                out_valid_r <= 1'b1;
                out_data_r  <= '0;
                out_user_r  <= {full, 1'b0};
                out_last_r  <= 1'b1;
              end
            end
          end
        end
        S_SCAN: begin
          if (rd_vld_r && new_score != '0) cand_r <= cand_r + 1'b1;
          if (done) begin
            pos_r  <= pos_inc;
            hc_r   <= pos_inc;
            want_r <= TOP_W'(want_calc);
            k_r    <= '0;
            have_r <= 1'b0;
            cnt_r  <= '0;
          end
        end
        S_SEL: begin
          if (rd_vld_r && take) begin
            have_r     <= 1'b1;
            best_key_r <= key_q;
          end
        end
        S_EMIT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            cnt_r       <= '0;
            if (have_r) begin
              out_data_r <= OUT_W'({cand_r, best_key_r[KEY_W-CNT_W-ID_W-1:ENT_W],
                                    best_key_r[KEY_W-CNT_W-1:KEY_W-CNT_W-ID_W],
                                    MC_W'(hc_r), MC_W'(best_key_r[KEY_W-1:KEY_W-CNT_W])});
              out_user_r <= 2'b01;
              out_last_r <= (k_r + 1'b1 == want_r);
              k_r        <= k_r + 1'b1;
              prev_key_r <= best_key_r;
              have_r     <= 1'b0;
            end else begin
              out_data_r <= OUT_W'({cand_r, {(2*ID_W){1'b0}}, MC_W'(hc_r), {MC_W{1'b0}}});
              out_user_r <= 2'b00;
              out_last_r <= 1'b1;
            end
          end
        end
        S_CLEAR: begin
          if (!issue) pos_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;
endmodule
`default_nettype wire

[rtl/core/mhsm_checker.sv]
// Port checker for the MinHash signature match block and its bind statement.
`default_nettype none
module mhsm_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       in_tready,
  input wire                       out_tvalid,
  input wire                       out_tready,
  input wire [mhsm_pkg::OUT_W-1:0] out_tdata,
  input wire [1:0]                 out_tuser,
  input wire                       out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result request dropped or changed while stalled");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("row without a match is not the last row");
  a_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[6:0] != 7'd0 && out_tdata[6:0] <= out_tdata[13:7])
    else $error("reported match count out of range");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && out_tlast)
    else $error("dropped add row carries a match");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while a result is waiting");
endmodule

bind minhash_signature_match_top_n mhsm_checker u_mhsm_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);
`default_nettype wire
